[src/isp_pkg.sv]
// ----------------------------------------------------------------------------
// isp_pkg
// Shared constants and divider interface types for the segment partitioner.
// ----------------------------------------------------------------------------
package isp_pkg;

   localparam int MAX_SEG_DEF = 32;
   localparam int DIM_W       = 16;
   localparam int SEG_W       = 6;
   localparam int DVD_W       = 22;
   localparam int DVS_W       = 7;

   localparam logic STAT_OK  = 1'b0;
   localparam logic STAT_BAD = 1'b1;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

endpackage

[src/isp_div.sv]
// ----------------------------------------------------------------------------
// isp_div
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module isp_div import isp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[src/image_segment_partitioner.sv]
// ----------------------------------------------------------------------------
// image_segment_partitioner
// Splits an image into segment_count near-equal rectangles, raster order.
// ----------------------------------------------------------------------------
// Usage:
//   An item (width, height, segment count) is taken when start is high and
//   busy is low. busy stays high until the last result of that item has been
//   emitted. Each result appears for one cycle with rsp_strobe high; the
//   receiver cannot stall, so results are never held back.
//   A bad count (zero, above MAX_SEGMENTS, above the pixel count) gives one
//   result with rsp_status and rsp_last set, after states ST_WH and ST_CHK.
//   A good item passes setup states ST_WH, ST_CHK, ST_HS and ST_CND, then
//   the row search when it is needed (ST_SRM and ST_SRC per row count
//   tried), then four divisions on one shared serial divider, six when
//   there is a bottom region, with the multiply states ST_M1 and ST_M2
//   between the first and second division, then emits one segment per cycle.
//   A single shared 16x16 multiplier with a registered product serves all
//   products. Reset returns the sequencer to idle and drops rsp_strobe.
// ----------------------------------------------------------------------------
module image_segment_partitioner import isp_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [DIM_W-1:0] req_image_width,
   input  logic [DIM_W-1:0] req_image_height,
   input  logic [SEG_W-1:0] req_segment_count,
   output logic             rsp_strobe,
   output logic             rsp_status,
   output logic [SEG_W-1:0] rsp_segment_number,
   output logic [DIM_W-1:0] rsp_row_offset,
   output logic [DIM_W-1:0] rsp_col_offset,
   output logic [DIM_W-1:0] rsp_seg_width,
   output logic [DIM_W-1:0] rsp_seg_height,
   output logic             rsp_last
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_WH   = 4'd1;
   localparam logic [3:0] ST_CHK  = 4'd2;
   localparam logic [3:0] ST_HS   = 4'd3;
   localparam logic [3:0] ST_CND  = 4'd4;
   localparam logic [3:0] ST_SRM  = 4'd5;
   localparam logic [3:0] ST_SRC  = 4'd6;
   localparam logic [3:0] ST_DGO  = 4'd7;
   localparam logic [3:0] ST_DWT  = 4'd8;
   localparam logic [3:0] ST_M1   = 4'd9;
   localparam logic [3:0] ST_M2   = 4'd10;
   localparam logic [3:0] ST_EMIT = 4'd11;

   localparam logic [2:0] OP_C  = 3'd0;
   localparam logic [2:0] OP_HT = 3'd1;
   localparam logic [2:0] OP_XT = 3'd2;
   localparam logic [2:0] OP_YT = 3'd3;
   localparam logic [2:0] OP_XB = 3'd4;
   localparam logic [2:0] OP_YB = 3'd5;

   localparam logic [SEG_W:0] MAX_SEG_V = (SEG_W+1)'(MAX_SEGMENTS);

   logic [3:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic [DIM_W-1:0] w_ff, w_in, h_ff, h_in;
   logic [SEG_W-1:0] s_ff, s_in;
   logic [31:0]      prod_ff, prod_in;
   logic [21:0]      tgt_ff, tgt_in;
   logic [SEG_W-1:0] r_ff, r_in;
   logic [11:0]      rr_ff, rr_in;
   logic [SEG_W-1:0] c_ff, c_in, rt_ff, rt_in, rt0_ff, rt0_in, rb0_ff, rb0_in;
   logic [DIM_W-1:0] ht_ff, ht_in, xt_ff, xt_in, yt_ff, yt_in;
   logic [DIM_W-1:0] xb_ff, xb_in, yb_ff, yb_in;
   logic [SEG_W:0]   ct0_ff, ct0_in, cb0_ff, cb0_in;
   logic             region_ff, region_in;
   logic [SEG_W-1:0] row_ff, row_in, k_ff, k_in;
   logic [SEG_W:0]   col_ff, col_in;
   logic [DIM_W-1:0] rpos_ff, rpos_in, cpos_ff, cpos_in;

   logic             strobe_ff, strobe_in, status_ff, status_in, last_ff, last_in;
   logic [SEG_W-1:0] num_ff, num_in;
   logic [DIM_W-1:0] ro_ff, ro_in, co_ff, co_in, sw_ff, sw_in, sh_ff, sh_in;

   logic [DIM_W-1:0] mul_a, mul_b;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   logic [SEG_W:0]   cur_cols, cur_c0;
   logic [DIM_W-1:0] cur_x, cur_y;
   logic [SEG_W-1:0] cur_r0;
   logic [DIM_W-1:0] cur_sw, cur_sh;
   logic [SEG_W-1:0] k_next;
   logic             err;

   isp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         ST_WH: begin
            mul_a = w_ff;
            mul_b = h_ff;
         end
         ST_CHK: begin
            mul_a = h_ff;
            mul_b = DIM_W'(s_ff);
         end
         ST_HS: begin
            mul_a = DIM_W'(s_ff - SEG_W'(1));
            mul_b = w_ff;
         end
         ST_SRM: begin
            mul_a = DIM_W'(rr_ff);
            mul_b = w_ff;
         end
         ST_M1: begin
            mul_a = DIM_W'(c_ff);
            mul_b = DIM_W'(rt_ff);
         end
         ST_M2: begin
            mul_a = h_ff;
            mul_b = prod_ff[DIM_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 32'(mul_a) * 32'(mul_b);

   // divider operands
   always_comb begin
      div_req.start = (state_ff == ST_DGO);
      unique case (op_ff)
         OP_C: begin
            div_req.dividend = DVD_W'(s_ff);
            div_req.divisor  = DVS_W'(r_ff);
         end
         OP_HT: begin
            div_req.dividend = prod_ff[DVD_W-1:0] + DVD_W'(s_ff[SEG_W-1:1]);
            div_req.divisor  = DVS_W'(s_ff);
         end
         OP_XT: begin
            div_req.dividend = DVD_W'(w_ff);
            div_req.divisor  = DVS_W'(c_ff);
         end
         OP_YT: begin
            div_req.dividend = DVD_W'(ht_ff);
            div_req.divisor  = DVS_W'(rt_ff);
         end
         OP_XB: begin
            div_req.dividend = DVD_W'(w_ff);
            div_req.divisor  = DVS_W'(c_ff) + DVS_W'(1);
         end
         OP_YB: begin
            div_req.dividend = DVD_W'(h_ff - ht_ff);
            div_req.divisor  = DVS_W'(r_ff - rt_ff);
         end
         default: begin
            div_req.dividend = '0;
            div_req.divisor  = '0;
         end
      endcase
   end

   // current region parameters for emission
   always_comb begin
      if (region_ff) begin
         cur_cols = {1'b0, c_ff} + (SEG_W+1)'(1);
         cur_x    = xb_ff;
         cur_c0   = cb0_ff;
         cur_y    = yb_ff;
         cur_r0   = rb0_ff;
      end else begin
         cur_cols = {1'b0, c_ff};
         cur_x    = xt_ff;
         cur_c0   = ct0_ff;
         cur_y    = yt_ff;
         cur_r0   = rt0_ff;
      end
      cur_sw = cur_x + DIM_W'(col_ff >= cur_c0);
      cur_sh = cur_y + DIM_W'(row_ff >= cur_r0);
      k_next = k_ff + SEG_W'(1);
      err    = (s_ff == '0) || ({1'b0, s_ff} > MAX_SEG_V) || (32'(s_ff) > prod_ff);
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      s_in      = s_ff;
      tgt_in    = tgt_ff;
      r_in      = r_ff;
      rr_in     = rr_ff;
      c_in      = c_ff;
      rt_in     = rt_ff;
      ht_in     = ht_ff;
      xt_in     = xt_ff;
      ct0_in    = ct0_ff;
      yt_in     = yt_ff;
      rt0_in    = rt0_ff;
      xb_in     = xb_ff;
      cb0_in    = cb0_ff;
      yb_in     = yb_ff;
      rb0_in    = rb0_ff;
      region_in = region_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      k_in      = k_ff;
      rpos_in   = rpos_ff;
      cpos_in   = cpos_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      num_in    = num_ff;
      ro_in     = ro_ff;
      co_in     = co_ff;
      sw_in     = sw_ff;
      sh_in     = sh_ff;
      last_in   = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               w_in     = req_image_width;
               h_in     = req_image_height;
               s_in     = req_segment_count;
               state_in = ST_WH;
            end
         end
         ST_WH: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (err) begin
               strobe_in = 1'b1;
               status_in = STAT_BAD;
               num_in    = '0;
               ro_in     = '0;
               co_in     = '0;
               sw_in     = '0;
               sh_in     = '0;
               last_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_HS;
            end
         end
         ST_HS: begin
            tgt_in   = prod_ff[21:0];
            state_in = ST_CND;
         end
         ST_CND: begin
            if (32'(h_ff) > prod_ff) begin
               r_in     = s_ff;
               op_in    = OP_C;
               state_in = ST_DGO;
            end else begin
               r_in     = SEG_W'(1);
               rr_in    = 12'd2;
               state_in = ST_SRM;
            end
         end
         ST_SRM: begin
            state_in = ST_SRC;
         end
         ST_SRC: begin
            if (r_ff < s_ff && prod_ff < 32'(tgt_ff)) begin
               r_in     = r_ff + SEG_W'(1);
               rr_in    = rr_ff + {5'b0, r_ff, 1'b0} + 12'd2;
               state_in = ST_SRM;
            end else begin
               op_in    = OP_C;
               state_in = ST_DGO;
            end
         end
         ST_DGO: begin
            state_in = ST_DWT;
         end
         ST_DWT: begin
            if (div_rsp.done) begin
               unique case (op_ff)
                  OP_C: begin
                     c_in     = div_rsp.quotient[SEG_W-1:0];
                     rt_in    = r_ff - div_rsp.remainder[SEG_W-1:0];
                     state_in = ST_M1;
                  end
                  OP_HT: begin
                     if (div_rsp.quotient[DIM_W-1:0] < DIM_W'(rt_ff)) begin
                        ht_in = DIM_W'(rt_ff);
                     end else begin
                        ht_in = div_rsp.quotient[DIM_W-1:0];
                     end
                     op_in    = OP_XT;
                     state_in = ST_DGO;
                  end
                  OP_XT: begin
                     xt_in    = div_rsp.quotient[DIM_W-1:0];
                     ct0_in   = {1'b0, c_ff} - div_rsp.remainder;
                     op_in    = OP_YT;
                     state_in = ST_DGO;
                  end
                  OP_YT: begin
                     yt_in  = div_rsp.quotient[DIM_W-1:0];
                     rt0_in = rt_ff - div_rsp.remainder[SEG_W-1:0];
                     xb_in  = '0;
                     cb0_in = '0;
                     yb_in  = '0;
                     rb0_in = '0;
                     if (rt_ff < r_ff && ht_ff <= h_ff) begin
                        op_in    = OP_XB;
                        state_in = ST_DGO;
                     end else begin
                        region_in = 1'b0;
                        row_in    = '0;
                        col_in    = '0;
                        k_in      = '0;
                        rpos_in   = '0;
                        cpos_in   = '0;
                        state_in  = ST_EMIT;
                     end
                  end
                  OP_XB: begin
                     xb_in    = div_rsp.quotient[DIM_W-1:0];
                     cb0_in   = {1'b0, c_ff} + (SEG_W+1)'(1) - div_rsp.remainder;
                     op_in    = OP_YB;
                     state_in = ST_DGO;
                  end
                  OP_YB: begin
                     yb_in     = div_rsp.quotient[DIM_W-1:0];
                     rb0_in    = (r_ff - rt_ff) - div_rsp.remainder[SEG_W-1:0];
                     region_in = 1'b0;
                     row_in    = '0;
                     col_in    = '0;
                     k_in      = '0;
                     rpos_in   = '0;
                     cpos_in   = '0;
                     state_in  = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_M1: begin
            state_in = ST_M2;
         end
         ST_M2: begin
            op_in    = OP_HT;
            state_in = ST_DGO;
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            status_in = STAT_OK;
            num_in    = k_next;
            ro_in     = rpos_ff;
            co_in     = cpos_ff;
            sw_in     = cur_sw;
            sh_in     = cur_sh;
            last_in   = (k_next == s_ff);
            k_in      = k_next;
            if (col_ff == cur_cols - (SEG_W+1)'(1)) begin
               col_in  = '0;
               cpos_in = '0;
               rpos_in = rpos_ff + cur_sh;
               if (!region_ff && row_ff == rt_ff - SEG_W'(1)) begin
                  region_in = 1'b1;
                  row_in    = '0;
               end else begin
                  row_in = row_ff + SEG_W'(1);
               end
            end else begin
               col_in  = col_ff + (SEG_W+1)'(1);
               cpos_in = cpos_ff + cur_sw;
            end
            if (k_next == s_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      op_ff     <= op_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      s_ff      <= s_in;
      prod_ff   <= prod_in;
      tgt_ff    <= tgt_in;
      r_ff      <= r_in;
      rr_ff     <= rr_in;
      c_ff      <= c_in;
      rt_ff     <= rt_in;
      ht_ff     <= ht_in;
      xt_ff     <= xt_in;
      ct0_ff    <= ct0_in;
      yt_ff     <= yt_in;
      rt0_ff    <= rt0_in;
      xb_ff     <= xb_in;
      cb0_ff    <= cb0_in;
      yb_ff     <= yb_in;
      rb0_ff    <= rb0_in;
      region_ff <= region_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      k_ff      <= k_in;
      rpos_ff   <= rpos_in;
      cpos_ff   <= cpos_in;
      status_ff <= status_in;
      num_ff    <= num_in;
      ro_ff     <= ro_in;
      co_ff     <= co_in;
      sw_ff     <= sw_in;
      sh_ff     <= sh_in;
      last_ff   <= last_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_segment_number = num_ff;
   assign rsp_row_offset     = ro_ff;
   assign rsp_col_offset     = co_ff;
   assign rsp_seg_width      = sw_ff;
   assign rsp_seg_height     = sh_ff;
   assign rsp_last           = last_ff;

   a_err_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STAT_BAD |-> rsp_last && rsp_segment_number == '0)
      else $error("error item without last or with a segment number");

   a_ok_number: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STAT_OK |-> rsp_segment_number != '0)
      else $error("segment item with number zero");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe)
      else $error("item emitted while idle");

endmodule

[verif/image_segment_partitioner_tb.sv]
// ----------------------------------------------------------------------------
// image_segment_partitioner_tb
// Self-checking bench: drives image sizes and segment counts with random
// gaps, predicts every segment rectangle and checks each strobed result.
// ----------------------------------------------------------------------------
module image_segment_partitioner_tb import isp_pkg::*;;

   localparam int           IDLE_LIMIT = 6000;
   localparam int           DRAIN_CYCLES = 300;
   localparam int           RANDOM_ITEMS = 98;

   typedef struct packed {
      logic             status;
      logic [SEG_W-1:0] seg_number;
      logic [DIM_W-1:0] row_off;
      logic [DIM_W-1:0] col_off;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             last;
   } seg_result_type;

   class partition_scoreboard;
      seg_result_type segments_q[$];
      int unsigned mismatches = 0;
      int unsigned items_seen = 0;
      int unsigned rejects = 0;
      int unsigned results_seen = 0;

      function int pending();
         return segments_q.size();
      endfunction

      // one region of equal-ish rows and columns, raster order
      function void add_region(inout int k, input longint unsigned total,
                               input longint unsigned rows, cols, x, c0, y, r0,
                               inout longint unsigned row_pos);
         longint unsigned row, col, sh, sw, col_pos;
         seg_result_type  e;
         for (row = 0; row < rows; row++) begin
            sh = y + ((row >= r0) ? 1 : 0);
            col_pos = 0;
            for (col = 0; col < cols; col++) begin
               sw = x + ((col >= c0) ? 1 : 0);
               if (k < total && k < MAX_SEG_DEF) begin
                  e.status     = STAT_OK;
                  e.seg_number = SEG_W'(k + 1);
                  e.row_off    = row_pos[15:0];
                  e.col_off    = col_pos[15:0];
                  e.width      = sw[15:0];
                  e.height     = sh[15:0];
                  e.last       = (k + 1 == total);
                  segments_q.push_back(e);
                  k++;
               end
               col_pos += sw;
            end
            row_pos += sh;
         end
      endfunction

      function void note_item(logic [DIM_W-1:0] wi, logic [DIM_W-1:0] hi,
                              logic [SEG_W-1:0] si);
         longint unsigned w, h, s, r, c, rt, ht, xt, ct0, yt, rt0;
         longint unsigned xb, cb0, yb, rb0, row_pos;
         int              k;
         seg_result_type  e;
         w = 64'(wi);
         h = 64'(hi);
         s = 64'(si);
         xb = 0;
         cb0 = 0;
         yb = 0;
         rb0 = 0;
         row_pos = 0;
         k = 0;
         items_seen++;
         if (s == 0 || s > MAX_SEG_DEF || s > w * h) begin
            e = '0;
            e.status = STAT_BAD;
            e.last = 1'b1;
            segments_q.push_back(e);
            rejects++;
            return;
         end
         if (h > (s - 1) * w) begin
            r = s;
         end else begin
            r = 1;
            while (r < s && (r + 1) * r * w < h * s) r++;
         end
         c   = s / r;
         rt  = (c + 1) * r - s;
         ht  = ((2 * h * c * rt + s) / 2) / s;
         if (ht < rt) ht = rt;
         xt  = w / c;
         ct0 = (xt + 1) * c - w;
         yt  = ht / rt;
         rt0 = (yt + 1) * rt - ht;
         if (rt < r && ht <= h) begin
            xb  = w / (c + 1);
            cb0 = (xb + 1) * (c + 1) - w;
            yb  = (h - ht) / (r - rt);
            rb0 = (yb + 1) * (r - rt) - (h - ht);
         end
         add_region(k, s, rt, c, xt, ct0, yt, rt0, row_pos);
         if (rt < r) add_region(k, s, r - rt, c + 1, xb, cb0, yb, rb0, row_pos);
      endfunction

      function void field_check(string name, longint unsigned want,
                                longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(seg_result_type got);
         seg_result_type want;
         results_seen++;
         if (segments_q.size() == 0) begin
            $error("result with no item outstanding: segment_number %0d",
                   got.seg_number);
            mismatches++;
            return;
         end
         want = segments_q.pop_front();
         field_check("status", 64'(want.status), 64'(got.status));
         field_check("segment_number", 64'(want.seg_number), 64'(got.seg_number));
         field_check("row_offset", 64'(want.row_off), 64'(got.row_off));
         field_check("col_offset", 64'(want.col_off), 64'(got.col_off));
         field_check("seg_width", 64'(want.width), 64'(got.width));
         field_check("seg_height", 64'(want.height), 64'(got.height));
         field_check("last", 64'(want.last), 64'(got.last));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [DIM_W-1:0] req_image_width = '0;
   logic [DIM_W-1:0] req_image_height = '0;
   logic [SEG_W-1:0] req_segment_count = '0;
   logic             rsp_strobe;
   logic             rsp_status;
   logic [SEG_W-1:0] rsp_segment_number;
   logic [DIM_W-1:0] rsp_row_offset;
   logic [DIM_W-1:0] rsp_col_offset;
   logic [DIM_W-1:0] rsp_seg_width;
   logic [DIM_W-1:0] rsp_seg_height;
   logic             rsp_last;

   partition_scoreboard sb = new();
   seg_result_type      seen_result;
   int                  idle_cycles = 0;
   bit                  no_idle = 1'b0;

   image_segment_partitioner uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_image_width    (req_image_width),
      .req_image_height   (req_image_height),
      .req_segment_count  (req_segment_count),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_segment_number (rsp_segment_number),
      .rsp_row_offset     (rsp_row_offset),
      .rsp_col_offset     (rsp_col_offset),
      .rsp_seg_width      (rsp_seg_width),
      .rsp_seg_height     (rsp_seg_height),
      .rsp_last           (rsp_last)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_result.status     = rsp_status;
         seen_result.seg_number = rsp_segment_number;
         seen_result.row_off    = rsp_row_offset;
         seen_result.col_off    = rsp_col_offset;
         seen_result.width      = rsp_seg_width;
         seen_result.height     = rsp_seg_height;
         seen_result.last       = rsp_last;
         sb.check_result(seen_result);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("no progress for %0d cycles", IDLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (no_idle || p < 40) return 0;
      if (p < 85) return $urandom_range(1, 4);
      return $urandom_range(5, 300);
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      int p;
      p = $urandom_range(0, 99);
      if (p < 30) return DIM_W'($urandom_range(1, 8));
      if (p < 55) return DIM_W'($urandom_range(1, 300));
      if (p < 85) return DIM_W'($urandom_range(1, 65535));
      if (p < 88) return '0;
      return DIM_W'($urandom_range(32768, 65535));
   endfunction

   function automatic logic [SEG_W-1:0] pick_count();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) return SEG_W'($urandom_range(1, MAX_SEG_DEF));
      if (p < 90) return SEG_W'($urandom_range(MAX_SEG_DEF + 1, 63));
      if (p < 95) return '0;
      return SEG_W'(MAX_SEG_DEF);
   endfunction

   // start stays high from one item to the next when there is no gap
   task automatic drive_item(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                             logic [SEG_W-1:0] s);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_image_width   <= w;
      req_image_height  <= h;
      req_segment_count <= s;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(w, h, s);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      drive_item(16'd65535, 16'd65535, 6'd32);
      drive_item(16'd1, 16'd1, 6'd1);
      drive_item(16'd65535, 16'd65535, 6'd1);
      drive_item(16'd100, 16'd80, 6'd0);
      drive_item(16'd100, 16'd80, 6'd33);
      drive_item(16'd65535, 16'd65535, 6'd63);
      drive_item(16'd2, 16'd3, 6'd7);
      drive_item(16'd0, 16'd50, 6'd1);
      drive_item(16'd50, 16'd0, 6'd1);
      drive_item(16'd0, 16'd0, 6'd0);
      drive_item(16'd1, 16'd65535, 6'd32);
      drive_item(16'd65535, 16'd1, 6'd32);
      drive_item(16'd3, 16'd2, 6'd6);
      drive_item(16'd5, 16'd5, 6'd25);
      drive_item(16'd2, 16'd3, 6'd5);
      drive_item(16'd2, 16'd2, 6'd3);
      drive_item(16'd7, 16'd3, 6'd13);
      drive_item(16'd4, 16'd9, 6'd31);
      drive_item(16'd1920, 16'd1080, 6'd7);
      drive_item(16'd33, 16'd1, 6'd32);
      drive_item(16'd640, 16'd480, 6'd17);
      drive_item(16'd1, 16'd32, 6'd32);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         no_idle = ((i / 20) % 3 == 2);
         drive_item(pick_dim(), pick_dim(), pick_count());
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d partitions driven, %0d of them rejected as bad counts",
               sb.items_seen, sb.rejects);
      $display("%0d results checked, %0d mismatches", sb.results_seen,
               sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
src/isp_pkg.sv
src/isp_div.sv
src/image_segment_partitioner.sv
verif/image_segment_partitioner_tb.sv
